// ----- sv/gcc_pkg.sv -----
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared widths, constants, item tags and constant functions for the gas
// curve concentration pipeline.
// ----------------------------------------------------------------------------
package gcc_pkg;

   // Field and register widths
   localparam int RATIO_W   = 24;
   localparam int MODE_W    = 2;
   localparam int CURVE_W   = 16;
   localparam int CSR_IDX_W = 3;

   // Default values of the top-level parameters
   localparam int RATIO_FRAC_BITS_DEF = 16;
   localparam int CURVE_FRAC_BITS_DEF = 12;
   localparam int PPM_BITS_DEF        = 20;

   // Internal fixed point: logs and exponents carry 24 fraction bits
   localparam int IFRAC  = 24;
   // Mantissa in Q.30, in [1, 2) for any nonzero ratio
   localparam int NORM_W = 31;
   // Index of the top set bit of a ratio
   localparam int POS_W  = 5;
   // Integer part of log2, signed
   localparam int EXP_W  = 7;
   localparam int L2_W   = EXP_W + IFRAC;

   // log10(2) in Q0.32
   localparam int LOG10_2_W = 31;
   localparam logic [LOG10_2_W-1:0] LOG10_OF_2_Q32 = 31'd1292913987;
   localparam int LG_W = L2_W + LOG10_2_W + 1 - 32;

   // log2(10) in Q2.30
   localparam int LOG2_10_W = 32;
   localparam logic [LOG2_10_W-1:0] LOG2_OF_10_Q30 = 32'd3566893132;

   // Exponent argument below 10 in Q.24, its base-2 form and the result
   localparam int XP_W       = 28;
   localparam int T_W        = 30;
   localparam int E_W        = 6;
   localparam int VAL_W      = 34;
   localparam int POW_SH_MAX = 33;
   localparam logic [NORM_W-1:0] ONE_Q30 = 31'h4000_0000;

   // Gas select codes
   localparam logic [MODE_W-1:0] MODE_LPG   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SMOKE = 2'd1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LPG_POINT_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LPG_POINT_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LPG_SLOPE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOKE_POINT_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOKE_POINT_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOKE_SLOPE   = 3'd5;

   // Register reset values, signed Q4.12
   localparam logic signed [CURVE_W-1:0] LPG_POINT_X_RST   = 16'sd9421;
   localparam logic signed [CURVE_W-1:0] LPG_POINT_Y_RST   = 16'sd819;
   localparam logic signed [CURVE_W-1:0] LPG_SLOPE_RST     = -16'sd1843;
   localparam logic signed [CURVE_W-1:0] SMOKE_POINT_X_RST = 16'sd9421;
   localparam logic signed [CURVE_W-1:0] SMOKE_POINT_Y_RST = 16'sd2171;
   localparam logic signed [CURVE_W-1:0] SMOKE_SLOPE_RST   = -16'sd1761;

   // Side information that rides along the log unit
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              ratio_zero;
   } item_tag_type;

   // Side information that rides along the power unit
   typedef struct packed {
      logic invalid;
      logic force_zero;
      logic force_sat;
   } res_tag_type;

   // Integer square root, bit by bit; used at elaboration only
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem  = v;
      res  = '0;
      bitv = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // 2^(2^-k) in Q.30, each root taken from the one before
   function automatic logic [63:0] root_q30(input int k);
      logic [63:0] r;
      r = 64'h8000_0000;
      for (int j = 1; j <= k; j++) begin
         r = isqrt64(r << 30);
      end
      return r;
   endfunction

endpackage

// ----- sv/gcc_log_unit.sv -----
// ----------------------------------------------------------------------------
// gcc_log_unit
// Pipelined log10 of an unsigned fixed-point ratio: normalize, one squaring
// stage per fraction bit of log2, then a scale by log10(2). Result in Q.24.
// ----------------------------------------------------------------------------
module gcc_log_unit #(
   parameter int RATIO_FRAC_BITS = gcc_pkg::RATIO_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_valid,
   input  logic [gcc_pkg::RATIO_W-1:0]        in_ratio,
   input  gcc_pkg::item_tag_type              in_tag,
   output logic                               out_valid,
   output logic signed [gcc_pkg::LG_W-1:0]    out_log,
   output gcc_pkg::item_tag_type              out_tag
);
   import gcc_pkg::*;

   // Stage 0 is the normalizer, stages 1..IFRAC the squaring steps
   logic                valid_ff [0:IFRAC];
   logic [NORM_W-1:0]   m_ff     [0:IFRAC];
   logic [IFRAC-1:0]    frac_ff  [0:IFRAC];
   logic [EXP_W-1:0]    exp_ff   [0:IFRAC];
   item_tag_type        tag_ff   [0:IFRAC];

   logic [POS_W-1:0]    top_pos;
   logic [NORM_W-1:0]   m_in;
   logic [EXP_W-1:0]    exp_in;

   // Find the top set bit and align it to bit 30
   always_comb begin
      top_pos = '0;
      for (int i = 1; i < RATIO_W; i++) begin
         if (in_ratio[i]) begin
            top_pos = POS_W'(i);
         end
      end
      m_in   = NORM_W'(in_ratio) << (POS_W'(NORM_W - 1) - top_pos);
      exp_in = EXP_W'(top_pos) - EXP_W'(RATIO_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
      end
      if (adv) begin
         m_ff[0]    <= m_in;
         frac_ff[0] <= '0;
         exp_ff[0]  <= exp_in;
         tag_ff[0]  <= in_tag;
      end
   end

   // One fraction bit per stage: square, and halve when the square reaches 2
   for (genvar k = 1; k <= IFRAC; k++) begin : g_sq
      logic [2*NORM_W-1:0] sq;
      logic [NORM_W:0]     sq_hi;
      logic [NORM_W-1:0]   m_sq_in;
      logic [IFRAC-1:0]    frac_in;

      always_comb begin
         sq    = m_ff[k-1] * m_ff[k-1];
         sq_hi = sq[2*NORM_W-1:NORM_W-1];
         if (sq_hi[NORM_W]) begin
            m_sq_in = sq_hi[NORM_W:1];
         end else begin
            m_sq_in = sq_hi[NORM_W-1:0];
         end
         frac_in = {frac_ff[k-1][IFRAC-2:0], sq_hi[NORM_W]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (adv) begin
            m_ff[k]    <= m_sq_in;
            frac_ff[k] <= frac_in;
            exp_ff[k]  <= exp_ff[k-1];
            tag_ff[k]  <= tag_ff[k-1];
         end
      end
   end

   // Scale log2 by log10(2) and floor
   logic signed [L2_W-1:0]           l2;
   logic signed [L2_W+LOG10_2_W:0]   prod;
   logic signed [LG_W-1:0]           lg_in;
   logic signed [LG_W-1:0]           lg_ff;
   logic                             lg_valid_ff;
   item_tag_type                     lg_tag_ff;

   always_comb begin
      l2    = signed'({exp_ff[IFRAC], frac_ff[IFRAC]});
      prod  = l2 * signed'({1'b0, LOG10_OF_2_Q32});
      lg_in = prod[L2_W+LOG10_2_W -: LG_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_valid_ff <= 1'b0;
      end else if (adv) begin
         lg_valid_ff <= valid_ff[IFRAC];
      end
      if (adv) begin
         lg_ff     <= lg_in;
         lg_tag_ff <= tag_ff[IFRAC];
      end
   end

   assign out_valid = lg_valid_ff;
   assign out_log   = lg_ff;
   assign out_tag   = lg_tag_ff;

endmodule

// ----- sv/gcc_pow_unit.sv -----
// ----------------------------------------------------------------------------
// gcc_pow_unit
// Pipelined floor(10^x) for x in [0, 10) in Q.24: change to base 2, one
// root multiply per fraction bit, then the integer shift and saturation.
// ----------------------------------------------------------------------------
module gcc_pow_unit #(
   parameter int PPM_BITS = gcc_pkg::PPM_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [gcc_pkg::XP_W-1:0]     in_x,
   input  gcc_pkg::res_tag_type         in_tag,
   output logic                         out_valid,
   output logic [PPM_BITS-1:0]          out_ppm,
   output logic                         out_saturated,
   output logic                         out_invalid
);
   import gcc_pkg::*;

   // Stage 0 converts to base 2, stages 1..IFRAC apply the roots
   logic               valid_ff [0:IFRAC];
   logic [NORM_W-1:0]  q_ff     [0:IFRAC];
   logic [IFRAC-1:0]   f_ff     [0:IFRAC];
   logic [E_W-1:0]     e_ff     [0:IFRAC];
   res_tag_type        tag_ff   [0:IFRAC];

   logic [XP_W+LOG2_10_W-1:0] t_prod;
   logic [T_W-1:0]            t_in;

   // Multiply by log2(10) and split into integer and fraction
   always_comb begin
      t_prod = in_x * LOG2_OF_10_Q30;
      t_in   = t_prod[XP_W+LOG2_10_W-1 -: T_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
      end
      if (adv) begin
         q_ff[0]   <= ONE_Q30;
         f_ff[0]   <= t_in[IFRAC-1:0];
         e_ff[0]   <= t_in[T_W-1:IFRAC];
         tag_ff[0] <= in_tag;
      end
   end

   // Multiply in 2^(2^-k) when fraction bit k is set
   for (genvar k = 1; k <= IFRAC; k++) begin : g_root
      localparam logic [NORM_W-1:0] ROOT = NORM_W'(root_q30(k));
      logic [2*NORM_W-1:0] mul;
      logic [NORM_W-1:0]   q_in;

      always_comb begin
         mul = q_ff[k-1] * ROOT;
         if (f_ff[k-1][IFRAC-k]) begin
            q_in = mul[2*NORM_W-2:NORM_W-1];
         end else begin
            q_in = q_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (adv) begin
            q_ff[k]   <= q_in;
            f_ff[k]   <= f_ff[k-1];
            e_ff[k]   <= e_ff[k-1];
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   // Apply the integer exponent, then clamp to the output width
   logic [VAL_W-1:0]     value;
   logic                 too_big;
   logic [PPM_BITS-1:0]  ppm_in;
   logic                 sat_in;
   logic [PPM_BITS-1:0]  ppm_ff;
   logic                 sat_ff;
   logic                 invalid_ff;
   logic                 out_valid_ff;

   always_comb begin
      value   = {q_ff[IFRAC], {(VAL_W-NORM_W){1'b0}}}
                >> (E_W'(POW_SH_MAX) - e_ff[IFRAC]);
      too_big = |value[VAL_W-1:PPM_BITS];
      sat_in  = !tag_ff[IFRAC].force_zero && (tag_ff[IFRAC].force_sat || too_big);
      if (tag_ff[IFRAC].force_zero) begin
         ppm_in = '0;
      end else if (sat_in) begin
         ppm_in = '1;
      end else begin
         ppm_in = value[PPM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= valid_ff[IFRAC];
      end
      if (adv) begin
         ppm_ff     <= ppm_in;
         sat_ff     <= sat_in;
         invalid_ff <= tag_ff[IFRAC].invalid;
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_ppm       = ppm_ff;
   assign out_saturated = sat_ff;
   assign out_invalid   = invalid_ff;

endmodule

// ----- sv/gas_curve_concentration.sv -----
// ----------------------------------------------------------------------------
// gas_curve_concentration
// Gas concentration in ppm from a sensor resistance ratio and a log-log
// sensitivity curve per gas: x = (log10(ratio) - y0) / slope + x0,
// ppm = floor(10^x), saturated to the ppm width.
//
// Usage: the req channel carries one item per ratio (Q8.16) and gas select;
// the rsp channel returns one item with ppm, saturated and invalid. Both use
// valid/stall. The csr port writes the six curve registers; write them only
// while no item is in flight.
// Item path, in order: the log unit (normalize, one squaring per log2 fraction
// bit, log10 scale), the curve offset, the restoring divider, the x offset
// and the power unit. Throughput is one item per cycle while no result is
// held at the output by rsp_stall.
// Reset clears every valid bit and loads the default curves. When the
// receiver stalls a waiting result, the whole pipeline holds in place and
// req_stall rises; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module gas_curve_concentration #(
   parameter int RATIO_FRAC_BITS = gcc_pkg::RATIO_FRAC_BITS_DEF,
   parameter int CURVE_FRAC_BITS = gcc_pkg::CURVE_FRAC_BITS_DEF,
   parameter int PPM_BITS        = gcc_pkg::PPM_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [gcc_pkg::RATIO_W-1:0]     req_ratio,
   input  logic [gcc_pkg::MODE_W-1:0]      req_mode,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [PPM_BITS-1:0]             rsp_ppm,
   output logic                            rsp_saturated,
   output logic                            rsp_invalid,
   input  logic                            csr_write_en,
   input  logic [gcc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gcc_pkg::CURVE_W-1:0]     csr_wdata
);
   import gcc_pkg::*;

   localparam int SCALE_SH = IFRAC - CURVE_FRAC_BITS;
   localparam int PY_W     = CURVE_W + SCALE_SH;
   localparam int D_W      = ((LG_W > PY_W) ? LG_W : PY_W) + 1;
   localparam int DEN_W    = CURVE_W;
   localparam int NUM_W    = D_W + CURVE_FRAC_BITS;
   localparam int X_W      = NUM_W + 2;
   localparam logic [X_W-1:0] TEN_Q24 = X_W'(10) << IFRAC;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              qneg;
      logic              invalid;
      logic              kill;
   } div_tag_type;

   // Curve registers
   logic signed [CURVE_W-1:0] lpg_point_x_ff, lpg_point_y_ff, lpg_slope_ff;
   logic signed [CURVE_W-1:0] smoke_point_x_ff, smoke_point_y_ff, smoke_slope_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lpg_point_x_ff   <= LPG_POINT_X_RST;
         lpg_point_y_ff   <= LPG_POINT_Y_RST;
         lpg_slope_ff     <= LPG_SLOPE_RST;
         smoke_point_x_ff <= SMOKE_POINT_X_RST;
         smoke_point_y_ff <= SMOKE_POINT_Y_RST;
         smoke_slope_ff   <= SMOKE_SLOPE_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LPG_POINT_X:   lpg_point_x_ff   <= csr_wdata;
            CSR_LPG_POINT_Y:   lpg_point_y_ff   <= csr_wdata;
            CSR_LPG_SLOPE:     lpg_slope_ff     <= csr_wdata;
            CSR_SMOKE_POINT_X: smoke_point_x_ff <= csr_wdata;
            CSR_SMOKE_POINT_Y: smoke_point_y_ff <= csr_wdata;
            CSR_SMOKE_SLOPE:   smoke_slope_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance the whole pipeline unless a result is held at the output
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // log10 of the ratio
   item_tag_type           req_tag;
   logic                   lg_valid;
   logic signed [LG_W-1:0] lg_log;
   item_tag_type           lg_tag;

   assign req_tag.mode       = req_mode;
   assign req_tag.ratio_zero = (req_ratio == '0);

   gcc_log_unit #(
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_log (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_ratio  (req_ratio),
      .in_tag    (req_tag),
      .out_valid (lg_valid),
      .out_log   (lg_log),
      .out_tag   (lg_tag)
   );

   // Divider stages: index 0 holds the prepared operands
   logic              div_valid_ff [0:NUM_W];
   logic [NUM_W-1:0]  div_nq_ff    [0:NUM_W];
   logic [DEN_W-1:0]  div_rem_ff   [0:NUM_W];
   logic [DEN_W-1:0]  div_den_ff   [0:NUM_W];
   div_tag_type       div_tag_ff   [0:NUM_W];

   // Subtract the curve offset and take magnitudes of both operands
   logic signed [CURVE_W-1:0] sel_py, sel_sl;
   logic signed [D_W-1:0]     pys, lgx, diff_pos, diff_neg;
   logic [D_W-1:0]            nmag;
   logic [DEN_W-1:0]          dmag_in;
   logic [NUM_W-1:0]          num_in;
   logic                      known;
   div_tag_type               dtag_in;

   always_comb begin
      case (lg_tag.mode)
         MODE_LPG: begin
            sel_py = lpg_point_y_ff;
            sel_sl = lpg_slope_ff;
         end
         MODE_SMOKE: begin
            sel_py = smoke_point_y_ff;
            sel_sl = smoke_slope_ff;
         end
         default: begin
            sel_py = lpg_point_y_ff;
            sel_sl = lpg_slope_ff;
         end
      endcase
      known    = (lg_tag.mode == MODE_LPG) || (lg_tag.mode == MODE_SMOKE);
      pys      = D_W'(sel_py) <<< SCALE_SH;
      lgx      = D_W'(lg_log);
      diff_pos = lgx - pys;
      diff_neg = pys - lgx;
      nmag     = diff_pos[D_W-1] ? diff_neg : diff_pos;
      num_in   = {nmag, {CURVE_FRAC_BITS{1'b0}}};
      dmag_in  = sel_sl[CURVE_W-1] ? DEN_W'(-sel_sl) : DEN_W'(sel_sl);
      dtag_in.mode    = lg_tag.mode;
      dtag_in.qneg    = diff_pos[D_W-1] ^ sel_sl[CURVE_W-1];
      dtag_in.invalid = known && (lg_tag.ratio_zero || (sel_sl == '0));
      dtag_in.kill    = !known || lg_tag.ratio_zero || (sel_sl == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         div_valid_ff[0] <= lg_valid;
      end
      if (adv) begin
         div_nq_ff[0]  <= num_in;
         div_rem_ff[0] <= '0;
         div_den_ff[0] <= dmag_in;
         div_tag_ff[0] <= dtag_in;
      end
   end

   // Restoring division, one quotient bit per stage
   for (genvar j = 1; j <= NUM_W; j++) begin : g_div
      logic [DEN_W:0]   trial;
      logic             take;
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] nq_in;

      always_comb begin
         trial  = {div_rem_ff[j-1], div_nq_ff[j-1][NUM_W-1]};
         take   = trial >= {1'b0, div_den_ff[j-1]};
         rem_in = take ? DEN_W'(trial - {1'b0, div_den_ff[j-1]}) : trial[DEN_W-1:0];
         nq_in  = {div_nq_ff[j-1][NUM_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[j] <= 1'b0;
         end else if (adv) begin
            div_valid_ff[j] <= div_valid_ff[j-1];
         end
         if (adv) begin
            div_nq_ff[j]  <= nq_in;
            div_rem_ff[j] <= rem_in;
            div_den_ff[j] <= div_den_ff[j-1];
            div_tag_ff[j] <= div_tag_ff[j-1];
         end
      end
   end

   // Apply the quotient sign, add the reference point and classify x
   logic signed [CURVE_W-1:0] sel_px;
   logic [X_W-1:0]            pxs, qx, x_val;
   logic                      x_neg, x_big;
   res_tag_type               rtag_in;
   logic                      x_valid_ff;
   logic [XP_W-1:0]           x_ff;
   res_tag_type               x_tag_ff;
   div_tag_type               dq_tag;

   always_comb begin
      dq_tag = div_tag_ff[NUM_W];
      case (dq_tag.mode)
         MODE_LPG:   sel_px = lpg_point_x_ff;
         MODE_SMOKE: sel_px = smoke_point_x_ff;
         default:    sel_px = lpg_point_x_ff;
      endcase
      pxs   = X_W'(sel_px) <<< SCALE_SH;
      qx    = X_W'(div_nq_ff[NUM_W]);
      x_val = dq_tag.qneg ? (pxs - qx) : (pxs + qx);
      x_neg = x_val[X_W-1];
      x_big = !x_neg && (x_val >= TEN_Q24);
      rtag_in.invalid    = dq_tag.invalid;
      rtag_in.force_zero = dq_tag.kill || x_neg;
      rtag_in.force_sat  = !dq_tag.kill && x_big;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
      end else if (adv) begin
         x_valid_ff <= div_valid_ff[NUM_W];
      end
      if (adv) begin
         x_ff     <= x_val[XP_W-1:0];
         x_tag_ff <= rtag_in;
      end
   end

   // floor(10^x) and the output register
   gcc_pow_unit #(
      .PPM_BITS (PPM_BITS)
   ) u_pow (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (x_valid_ff),
      .in_x          (x_ff),
      .in_tag        (x_tag_ff),
      .out_valid     (rsp_valid),
      .out_ppm       (rsp_ppm),
      .out_saturated (rsp_saturated),
      .out_invalid   (rsp_invalid)
   );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gas_curve_concentration. A scoreboard class
// predicts ppm, saturated and invalid for every accepted item from its own
// fixed-point log10 / divide / 10^x computation and its copy of the curve
// registers. Results are checked in order. The run walks through default,
// random and extreme curve settings (zero slope included), with random
// idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

   localparam int PPM_W       = gcc_pkg::PPM_BITS_DEF;
   localparam int RATIO_FRAC  = gcc_pkg::RATIO_FRAC_BITS_DEF;
   localparam int CURVE_FRAC  = gcc_pkg::CURVE_FRAC_BITS_DEF;
   localparam int FRAC_BITS   = 24;
   localparam int LATENCY     = 98;
   localparam int LONG_HOLD   = 400;
   localparam int NUM_PHASES  = 10;
   localparam int PHASE_ITEMS = 195;
   localparam int CYCLE_LIMIT = 500000;

   // Gas selects with no curve behind them
   localparam logic [gcc_pkg::MODE_W-1:0] MODE_SPARE_2 = 2'd2;
   localparam logic [gcc_pkg::MODE_W-1:0] MODE_SPARE_3 = 2'd3;
   // Register slots past the curve set; writes there are dropped
   localparam logic [gcc_pkg::CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [gcc_pkg::CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   localparam logic [gcc_pkg::CURVE_W-1:0] CURVE_MAX = 16'h7FFF;
   localparam logic [gcc_pkg::CURVE_W-1:0] CURVE_MIN = 16'h8000;
   localparam logic [gcc_pkg::RATIO_W-1:0] RATIO_ONE = 24'h01_0000;

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic [PPM_W-1:0] ppm;
      logic             saturated;
      logic             invalid;
   } conc_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: curve copy, ppm prediction and in-order result check
   // -------------------------------------------------------------------------
   class ppm_scoreboard;
      conc_result_type expected_q[$];
      logic signed [gcc_pkg::CURVE_W-1:0] point_x [2];
      logic signed [gcc_pkg::CURVE_W-1:0] point_y [2];
      logic signed [gcc_pkg::CURVE_W-1:0] slope [2];
      u64_type half_roots [1:FRAC_BITS];
      int errors;
      int checked;
      int n_sat;
      int n_invalid;
      int n_in_range;

      function new();
         u64_type r, v, s, c;
         errors = 0;
         checked = 0;
         n_sat = 0;
         n_invalid = 0;
         n_in_range = 0;
         // 2^(2^-k) in Q.30: each root is the square root of the one before
         r = 64'h8000_0000;
         for (int k = 1; k <= FRAC_BITS; k++) begin
            v = r << 30;
            s = 0;
            for (int b = 31; b >= 0; b--) begin
               c = s | (64'd1 << b);
               if (c * c <= v) s = c;
            end
            half_roots[k] = s;
            r = s;
         end
         point_x[0] = gcc_pkg::LPG_POINT_X_RST;
         point_y[0] = gcc_pkg::LPG_POINT_Y_RST;
         slope[0]   = gcc_pkg::LPG_SLOPE_RST;
         point_x[1] = gcc_pkg::SMOKE_POINT_X_RST;
         point_y[1] = gcc_pkg::SMOKE_POINT_Y_RST;
         slope[1]   = gcc_pkg::SMOKE_SLOPE_RST;
      endfunction

      function void set_curve(logic [gcc_pkg::CSR_IDX_W-1:0] idx,
                              logic [gcc_pkg::CURVE_W-1:0] data);
         case (idx)
            gcc_pkg::CSR_LPG_POINT_X:   point_x[0] = data;
            gcc_pkg::CSR_LPG_POINT_Y:   point_y[0] = data;
            gcc_pkg::CSR_LPG_SLOPE:     slope[0]   = data;
            gcc_pkg::CSR_SMOKE_POINT_X: point_x[1] = data;
            gcc_pkg::CSR_SMOKE_POINT_Y: point_y[1] = data;
            gcc_pkg::CSR_SMOKE_SLOPE:   slope[1]   = data;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Predict the result of one accepted item and queue it
      function void note_request(logic [gcc_pkg::RATIO_W-1:0] ratio,
                                 logic [gcc_pkg::MODE_W-1:0] mode);
         conc_result_type res;
         int sel;
         int p;
         int e;
         u64_type m, t, q, value;
         longint frac, l2, lg, d, x;
         res = '0;
         if (mode == gcc_pkg::MODE_LPG || mode == gcc_pkg::MODE_SMOKE) begin
            sel = (mode == gcc_pkg::MODE_SMOKE) ? 1 : 0;
            if (ratio == 0 || slope[sel] == 0) begin
               res.invalid = 1'b1;
            end else begin
               // log2: normalize to [1,2) in Q.30, then square for each bit
               p = 23;
               while (p > 0 && !ratio[p]) p--;
               m = u64_type'(ratio) << (30 - p);
               frac = 0;
               for (int i = 0; i < FRAC_BITS; i++) begin
                  m = (m * m) >> 30;
                  frac = frac << 1;
                  if (m >= (64'd2 << 30)) begin
                     frac = frac | 1;
                     m = m >> 1;
                  end
               end
               l2 = longint'(p - RATIO_FRAC) * (64'sd1 << FRAC_BITS) + frac;
               // log10 by log10(2) in Q0.32, floored
               lg = (l2 * 64'sd1292913987) >>> 32;
               d = lg - longint'(point_y[sel]) * (64'sd1 << (FRAC_BITS - CURVE_FRAC));
               x = (d * (64'sd1 << CURVE_FRAC)) / longint'(slope[sel])
                   + longint'(point_x[sel]) * (64'sd1 << (FRAC_BITS - CURVE_FRAC));
               // below zero gives nothing; 10 and up saturates outright
               if (x >= (64'sd10 <<< FRAC_BITS)) begin
                  res.ppm = '1;
                  res.saturated = 1'b1;
               end else if (x >= 0) begin
                  t = (u64_type'(x) * 64'd3566893132) >> 30;
                  e = int'(t >> FRAC_BITS);
                  q = 64'd1 << 30;
                  for (int k = 1; k <= FRAC_BITS; k++) begin
                     if (t[FRAC_BITS - k]) q = (q * half_roots[k]) >> 30;
                  end
                  value = (e >= 30) ? (q << (e - 30)) : (q >> (30 - e));
                  if (value > u64_type'({PPM_W{1'b1}})) begin
                     res.ppm = '1;
                     res.saturated = 1'b1;
                  end else begin
                     res.ppm = value[PPM_W-1:0];
                  end
               end
            end
         end
         expected_q.push_back(res);
      endfunction

      // Compare one accepted result with the oldest prediction
      function void check_response(logic [PPM_W-1:0] ppm, logic sat, logic inv);
         conc_result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: result with nothing expected: ppm %0d sat %0b inv %0b",
                     $time, ppm, sat, inv);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (want.saturated) n_sat++;
         if (want.invalid) n_invalid++;
         if (!want.saturated && want.ppm != 0) n_in_range++;
         if (ppm !== want.ppm) begin
            $display("%0t: ppm mismatch: expected %0d, actual %0d", $time, want.ppm, ppm);
            errors++;
         end
         if (sat !== want.saturated) begin
            $display("%0t: saturated mismatch: expected %0b, actual %0b",
                     $time, want.saturated, sat);
            errors++;
         end
         if (inv !== want.invalid) begin
            $display("%0t: invalid mismatch: expected %0b, actual %0b",
                     $time, want.invalid, inv);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [gcc_pkg::RATIO_W-1:0] req_ratio = '0;
   logic [gcc_pkg::MODE_W-1:0] req_mode = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [PPM_W-1:0] rsp_ppm;
   logic rsp_saturated;
   logic rsp_invalid;
   logic csr_write_en = 1'b0;
   logic [gcc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [gcc_pkg::CURVE_W-1:0] csr_wdata = '0;

   bit send_gaps = 1'b0;
   bit recv_gaps = 1'b0;
   bit hold_long = 1'b0;
   int cycles = 0;
   int settings_used = 1;
   ppm_scoreboard board;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   gas_curve_concentration dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ratio     (req_ratio),
      .req_mode      (req_mode),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_ppm       (rsp_ppm),
      .rsp_saturated (rsp_saturated),
      .rsp_invalid   (rsp_invalid),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // Watch both channels; check before noting so the queue order holds
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            board.check_response(rsp_ppm, rsp_saturated, rsp_invalid);
         if (req_valid && !req_stall)
            board.note_request(req_ratio, req_mode);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycles);
         $display("testbench: errors");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 1'b0;
            rsp_stall <= 1'b0;
         end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   // Offer one item and hold it until it is taken
   task automatic send_item(logic [gcc_pkg::RATIO_W-1:0] ratio,
                            logic [gcc_pkg::MODE_W-1:0] mode);
      if (send_gaps && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ratio <= ratio;
      req_mode  <= mode;
      do @(posedge clock); while (req_stall);
   endtask

   // Random item: ratios spread over all magnitudes, mostly known gases
   task automatic send_random_item();
      logic [gcc_pkg::RATIO_W-1:0] ratio;
      logic [gcc_pkg::MODE_W-1:0] mode;
      if ($urandom_range(0, 31) == 0)
         ratio = '0;
      else if ($urandom_range(0, 3) == 0)
         ratio = gcc_pkg::RATIO_W'($urandom());
      else
         ratio = gcc_pkg::RATIO_W'($urandom()) >> $urandom_range(0, 23);
      if ($urandom_range(0, 9) < 8)
         mode = $urandom_range(0, 1) ? gcc_pkg::MODE_SMOKE : gcc_pkg::MODE_LPG;
      else
         mode = $urandom_range(0, 1) ? MODE_SPARE_3 : MODE_SPARE_2;
      send_item(ratio, mode);
   endtask

   // Drop valid and wait until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [gcc_pkg::CSR_IDX_W-1:0] idx,
                            logic [gcc_pkg::CURVE_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      board.set_curve(idx, data);
   endtask

   // Load both curves, poke the unused slots, then release the write port
   task automatic load_curves(logic [gcc_pkg::CURVE_W-1:0] lx, ly, ls, sx, sy, ss);
      write_reg(gcc_pkg::CSR_LPG_POINT_X, lx);
      write_reg(gcc_pkg::CSR_LPG_POINT_Y, ly);
      write_reg(gcc_pkg::CSR_LPG_SLOPE, ls);
      write_reg(CSR_SPARE_6, gcc_pkg::CURVE_W'($urandom()));
      write_reg(gcc_pkg::CSR_SMOKE_POINT_X, sx);
      write_reg(gcc_pkg::CSR_SMOKE_POINT_Y, sy);
      write_reg(gcc_pkg::CSR_SMOKE_SLOPE, ss);
      write_reg(CSR_SPARE_7, gcc_pkg::CURVE_W'($urandom()));
      csr_write_en <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   function automatic logic [gcc_pkg::CURVE_W-1:0] any_slope();
      if ($urandom_range(0, 3) == 0) return gcc_pkg::CURVE_W'($urandom_range(256, 8192));
      return -gcc_pkg::CURVE_W'($urandom_range(256, 8192));
   endfunction

   function automatic logic [gcc_pkg::CURVE_W-1:0] any_point_x();
      return gcc_pkg::CURVE_W'($urandom_range(0, 20000));
   endfunction

   function automatic logic [gcc_pkg::CURVE_W-1:0] any_point_y();
      return gcc_pkg::CURVE_W'($urandom_range(0, 8192)) - 16'd4096;
   endfunction

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      int phase;
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items on the reset curves
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
      send_item('0, gcc_pkg::MODE_LPG);
      send_item('0, gcc_pkg::MODE_SMOKE);
      send_item('0, MODE_SPARE_2);
      send_item('1, MODE_SPARE_3);
      send_item('1, gcc_pkg::MODE_LPG);
      send_item('1, gcc_pkg::MODE_SMOKE);
      send_item(24'h00_0001, gcc_pkg::MODE_LPG);
      send_item(24'h00_0001, gcc_pkg::MODE_SMOKE);
      send_item(24'h00_0200, gcc_pkg::MODE_LPG);
      send_item(24'h00_0100, gcc_pkg::MODE_SMOKE);
      send_item(24'h00_0400, gcc_pkg::MODE_LPG);
      send_item(RATIO_ONE, gcc_pkg::MODE_LPG);
      send_item(RATIO_ONE, gcc_pkg::MODE_SMOKE);
      send_item(24'h0A_0000, gcc_pkg::MODE_LPG);
      send_item(24'h0C_0000, gcc_pkg::MODE_SMOKE);
      send_item(24'h00_8000, gcc_pkg::MODE_LPG);
      send_item(24'h02_0000, gcc_pkg::MODE_SMOKE);
      send_item(24'h80_0000, gcc_pkg::MODE_LPG);
      send_item(24'h7F_FFFF, gcc_pkg::MODE_SMOKE);
      send_item(24'h00_1999, gcc_pkg::MODE_LPG);
      send_item(24'h00_4CCC, gcc_pkg::MODE_SMOKE);
      drain();

      // Random items under a run of curve settings
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: ;
            2: load_curves(CURVE_MAX, CURVE_MIN, CURVE_MIN, CURVE_MIN, CURVE_MAX, CURVE_MAX);
            3: load_curves(any_point_x(), any_point_y(), 16'h0000,
                           any_point_x(), any_point_y(), 16'h0001);
            4: load_curves(any_point_x(), any_point_y(), 16'hFFFF,
                           any_point_x(), any_point_y(), 16'h0000);
            5: load_curves(CURVE_MIN, CURVE_MAX, CURVE_MAX, CURVE_MAX, CURVE_MIN, CURVE_MIN);
            default: load_curves(any_point_x(), any_point_y(), any_slope(),
                                 any_point_x(), any_point_y(), any_slope());
         endcase
         // Mix the idling; the fill test needs a steady sender; the tail has none
         send_gaps = (phase % 3 != 2) && phase != 3 && phase != NUM_PHASES - 1;
         recv_gaps = (phase % 3 != 1) && phase != NUM_PHASES - 1;
         if (phase == 3) hold_long = 1'b1;
         repeat (PHASE_ITEMS) send_random_item();
         drain();
      end

      repeat (2 * LATENCY) @(posedge clock);
      $display("summary: %0d items checked under %0d curve settings, zero slopes and",
               board.checked, settings_used);
      $display("summary: full-scale registers included; %0d saturated, %0d invalid, %0d in range",
               board.n_sat, board.n_invalid, board.n_in_range);
      if (board.pending() != 0)
         $display("%0t: %0d expected results never arrived", $time, board.pending());
      if (board.errors == 0 && board.pending() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
